[src/lookahead_goal_selector_top_assert.svh]
// assertion macros shared by the lookahead goal selector modules
// both expect clk and rst_n in scope
`ifndef LOOKAHEAD_GOAL_SELECTOR_TOP_ASSERT_SVH
`define LOOKAHEAD_GOAL_SELECTOR_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define LGS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lgs_pkg.sv]
package lgs_pkg;

    // fixed field widths
    localparam int COORD_BITS     = 24;
    localparam int POS_BITS       = 10;
    localparam int TARGET_BITS    = 16;
    localparam int STEP_BITS      = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam int PATH_DEPTH_DEF = 1024;

    // operation codes
    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_POSE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP   = 1'b1;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET = 16'd2000;
    localparam logic [STEP_BITS-1:0]   STEP_RESET   = 8'd1;

    typedef struct packed {
        logic [1:0]                    operation;
        logic                          first_point;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  goal_x;
        logic signed [COORD_BITS-1:0]  goal_y;
        logic [POS_BITS-1:0]           goal_position;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic store_point;
        logic set_pose;
        logic start_tick;
        logic read_goal;
        logic load_diff;
        logic load_square;
        logic advance;
        logic load_result;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic path_ready;
        logic advance_ok;
        logic result_full;
    } status_t;

endpackage

[src/lgs_ram.sv]
module lgs_ram #(
    parameter int WIDTH = 2 * lgs_pkg::COORD_BITS,
    parameter int DEPTH = lgs_pkg::PATH_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/lgs_datapath.sv]
`include "lookahead_goal_selector_top_assert.svh"

module lgs_datapath #(
    parameter int PATH_DEPTH = lgs_pkg::PATH_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lgs_pkg::in_item_t                   item,
    input  logic                                cfg_write,
    input  logic [lgs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  lgs_pkg::cmd_t                       cmd,
    output lgs_pkg::status_t                    status,
    input  logic                                result_stall,
    output logic                                result_valid,
    output lgs_pkg::out_item_t                  result
);

    localparam int CW     = lgs_pkg::COORD_BITS;
    localparam int TW     = lgs_pkg::TARGET_BITS;
    localparam int SW     = lgs_pkg::STEP_BITS;
    localparam int PW     = lgs_pkg::POS_BITS;
    localparam int IDX_W  = $clog2(PATH_DEPTH);
    localparam int LEN_W  = $clog2(PATH_DEPTH + 1);
    localparam int STEP_W = (IDX_W > SW) ? IDX_W : SW;
    localparam int MAG_W  = CW + 1;
    localparam int SQ_W   = 2 * TW;

    // path bookkeeping
    logic [LEN_W-1:0]      length_reg, length_next;
    logic [IDX_W-1:0]      goal_reg, goal_next;
    logic                  have_path_reg, have_path_next;

    // pose and registers
    logic signed [CW-1:0]  robot_x_reg, robot_y_reg;
    logic [TW-1:0]         target_reg;
    logic [SW-1:0]         step_reg;
    logic [SQ_W-1:0]       tt_reg;

    // distance pipeline
    logic signed [CW-1:0]  point_x_reg, point_y_reg;
    logic [TW-1:0]         ax_reg, ay_reg;
    logic                  far_reg, far_sq_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;

    lgs_pkg::out_item_t    result_reg;
    logic                  result_valid_reg;

    // memory
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [2*CW-1:0]       ram_rdata;
    logic signed [CW-1:0]  rd_x, rd_y;

    logic [LEN_W-1:0]      last_wide;
    logic [IDX_W-1:0]      last_idx;
    logic signed [MAG_W-1:0] dx, dy;
    logic [MAG_W-1:0]      mag_x, mag_y;
    logic [SQ_W:0]         dist_sum;
    logic                  near;
    logic [IDX_W-1:0]      room;
    logic [SW-1:0]         step_eff;
    logic [STEP_W-1:0]     step_w, room_w, add_w;
    logic [IDX_W+PW-1:0]   goal_wide;

    assign ram_we    = cmd.store_point
                     && (item.first_point || (length_reg < LEN_W'(PATH_DEPTH)));
    assign ram_waddr = item.first_point ? '0 : length_reg[IDX_W-1:0];

    lgs_ram #(
        .WIDTH (2 * CW),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({item.x, item.y}),
        .re    (cmd.read_goal),
        .raddr (goal_reg),
        .rdata (ram_rdata)
    );

    assign rd_x = signed'(ram_rdata[2*CW-1:CW]);
    assign rd_y = signed'(ram_rdata[CW-1:0]);

    assign last_wide = length_reg - LEN_W'(1);
    assign last_idx  = last_wide[IDX_W-1:0];

    // absolute offsets, anything past 16 bits is out of any circle
    assign dx    = MAG_W'(rd_x) - MAG_W'(robot_x_reg);
    assign dy    = MAG_W'(rd_y) - MAG_W'(robot_y_reg);
    assign mag_x = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    assign mag_y = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign near     = !far_sq_reg && (dist_sum < {1'b0, tt_reg});

    // advance by the step, clipped at the last point
    assign room     = last_idx - goal_reg;
    assign step_eff = (step_reg == '0) ? SW'(1) : step_reg;
    assign step_w   = STEP_W'(step_eff);
    assign room_w   = STEP_W'(room);
    assign add_w    = (step_w < room_w) ? step_w : room_w;

    always_comb
    begin
        length_next    = length_reg;
        goal_next      = goal_reg;
        have_path_next = have_path_reg;
        priority if (cmd.store_point)
        begin
            if (item.first_point)
            begin
                length_next    = LEN_W'(1);
                goal_next      = '0;
                have_path_next = 1'b1;
            end
            else if (length_reg < LEN_W'(PATH_DEPTH))
            begin
                length_next = length_reg + LEN_W'(1);
            end
        end
        else if (cmd.start_tick)
        begin
            goal_next = (goal_reg > last_idx) ? last_idx : goal_reg;
        end
        else if (cmd.advance)
        begin
            goal_next = goal_reg + add_w[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg       <= '0;
            goal_reg         <= '0;
            have_path_reg    <= 1'b0;
            robot_x_reg      <= '0;
            robot_y_reg      <= '0;
            target_reg       <= lgs_pkg::TARGET_RESET;
            step_reg         <= lgs_pkg::STEP_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            goal_reg      <= goal_next;
            have_path_reg <= have_path_next;
            if (cmd.set_pose)
            begin
                robot_x_reg <= item.x;
                robot_y_reg <= item.y;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lgs_pkg::CFG_TARGET: target_reg <= cfg_data;
                    lgs_pkg::CFG_STEP:   step_reg   <= cfg_data[SW-1:0];
                endcase
            end
            if (cmd.load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_tick)
        begin
            tt_reg <= target_reg * target_reg;
        end
        if (cmd.load_diff)
        begin
            point_x_reg <= rd_x;
            point_y_reg <= rd_y;
            ax_reg      <= mag_x[TW-1:0];
            ay_reg      <= mag_y[TW-1:0];
            far_reg     <= (|mag_x[MAG_W-1:TW]) || (|mag_y[MAG_W-1:TW]);
        end
        if (cmd.load_square)
        begin
            sqx_reg    <= ax_reg * ax_reg;
            sqy_reg    <= ay_reg * ay_reg;
            far_sq_reg <= far_reg;
        end
        if (cmd.load_result)
        begin
            result_reg.goal_x        <= point_x_reg;
            result_reg.goal_y        <= point_y_reg;
            result_reg.goal_position <= goal_wide[PW-1:0];
        end
    end

    // position is the index masked to the output width
    assign goal_wide = {PW'(0), goal_reg};

    assign status.path_ready  = have_path_reg && (length_reg != '0);
    assign status.advance_ok  = near && (goal_reg < last_idx);
    assign status.result_full = result_valid_reg && result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LGS_ASSERT_IMPLY(a_goal_in_path, status.path_ready, goal_reg <= last_idx, "goal beyond last point")
    `LGS_ASSERT_IMPLY(a_length_bound, 1'b1, length_reg <= LEN_W'(PATH_DEPTH), "path length overflow")
    `LGS_ASSERT_NEXT(a_advance_moves, cmd.advance, goal_reg > $past(goal_reg), "advance did not move goal")
    `LGS_ASSERT_IMPLY(a_no_overwrite, cmd.load_result, !status.result_full, "pending result overwritten")

endmodule

[src/lgs_ctrl.sv]
`include "lookahead_goal_selector_top_assert.svh"

module lgs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [1:0]        item_op,
    input  lgs_pkg::status_t  status,
    output logic              item_stall,
    output lgs_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQUARE,
        S_COMPARE
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;
    logic   accept;

    assign accept = item_valid && !stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.store_point = accept && (item_op == lgs_pkg::OP_POINT);
                cmd.set_pose    = accept && (item_op == lgs_pkg::OP_POSE);
                cmd.start_tick  = accept && (item_op == lgs_pkg::OP_TICK)
                                  && status.path_ready;
                if (cmd.start_tick)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_goal = 1'b1;
                state_next    = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.load_diff = 1'b1;
                state_next    = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.load_square = 1'b1;
                state_next      = S_COMPARE;
            end
            S_COMPARE:
            begin
                priority if (status.advance_ok)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
                else if (!status.result_full)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign item_stall = stall_reg;

    `LGS_ASSERT_NEXT(a_tick_starts_walk, item_valid && !item_stall && (item_op == lgs_pkg::OP_TICK) && status.path_ready, state_reg == S_READ, "tick did not start walk")

endmodule

[src/lookahead_goal_selector_top.sv]
// lookahead goal selector: holds a path of signed millimetre (x,y) points in an on-chip
// memory plus the latest robot pose, and on each tick walks the goal index forward by
// index_step points while the goal point lies strictly inside target_distance of the
// robot and the index is below the last point, then returns one beat with that point and
// its index (index masked to 10 bits). a path beat with first_point set restarts the path
// at index 0; points past PATH_DEPTH are dropped; a pose beat replaces the pose; path and
// pose beats, ticks with no path loaded and operation 3 produce nothing. path and pose
// beats can arrive back to back. on a tick every examined point passes through a memory
// read, an offset stage, a squaring stage and a compare stage in the datapath; the input
// stalls for that whole walk. the finished result sits in an output register, so the next
// beat is taken while it waits; a following tick holds in its last stage until the earlier
// result is gone. the register port is always ready; write it only while the block is idle.
// the path memory has no reset: reading beyond what was loaded is not possible.

module lookahead_goal_selector_top #(
    parameter int PATH_DEPTH = lgs_pkg::PATH_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // input beats: path points, pose updates, ticks
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lgs_pkg::in_item_t                   item,

    // result beats: selected goal
    output logic                                result_valid,
    input  logic                                result_stall,
    output lgs_pkg::out_item_t                  result,

    // register writes: index 0 target_distance, index 1 index_step
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    lgs_pkg::cmd_t    cmd;
    lgs_pkg::status_t status;
    logic             cfg_write;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sequencer: dispatches beats and steps the per-point walk
    lgs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.operation),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // path memory, pose, distance pipeline and output register
    lgs_datapath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
